FILE: src/rpcp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpcp_pkg;

   localparam int ALPHABET    = 256;
   localparam int MAP_AW      = $clog2(ALPHABET);
   localparam int DICT_W      = 9;
   localparam int LEN_W       = 4;
   localparam int CODE_W      = 12;
   localparam int FIXED_RANKS = 7;
   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   localparam logic [2:0] ESC_PREFIX = 3'b010;
   localparam logic [DICT_W-1:0] DICT_RESET = 9'd256;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] byte_value;
      logic [7:0] rank;
   } rpcp_req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       last;
   } rpcp_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] operation;
      logic [7:0] byte_value;
      logic       hit;
      logic [7:0] mapped_rank;
   } rpcp_lookup_type;

   typedef struct packed {
      logic [1:0]   count;
      rpcp_rsp_type data0;
      rpcp_rsp_type data1;
   } rpcp_push_type;

   function automatic logic [4:0] fixed_value(input logic [2:0] rk);
      logic [4:0] v;
      unique case (rk)
         3'd0:    v = 5'd1;
         3'd1:    v = 5'd4;
         3'd2:    v = 5'd6;
         3'd3:    v = 5'd0;
         3'd4:    v = 5'd16;
         3'd5:    v = 5'd8;
         3'd6:    v = 5'd24;
         default: v = 5'd0;
      endcase
      return v;
   endfunction

   function automatic logic [LEN_W-1:0] fixed_length(input logic [2:0] rk);
      logic [LEN_W-1:0] l;
      unique case (rk)
         3'd0:    l = 4'd1;
         3'd1:    l = 4'd3;
         3'd2:    l = 4'd3;
         default: l = 4'd5;
      endcase
      return l;
   endfunction

   // 3 + bitsize(max(dict,1) - 1)
   function automatic logic [LEN_W-1:0] esc_length(input logic [DICT_W-1:0] dict);
      logic [DICT_W-1:0] v;
      logic [LEN_W-1:0]  n;
      v = (dict == '0) ? '0 : dict - 9'd1;
      n = '0;
      for (int i = 0; i < DICT_W; i++) begin
         if (v[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      return n + 4'd3;
   endfunction

endpackage

`default_nettype wire

FILE: src/rpcp_map.sv
`timescale 1ns / 1ps
`default_nettype none

module rpcp_map (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     take,
   input  wire rpcp_pkg::rpcp_req_type   req,
   input  wire logic                     advance,
   output rpcp_pkg::rpcp_lookup_type     lookup
);

   logic [7:0]                    rank_mem [rpcp_pkg::ALPHABET];
   logic [rpcp_pkg::ALPHABET-1:0] map_valid_ff;
   logic [rpcp_pkg::ALPHABET-1:0] map_valid_in;
   logic [rpcp_pkg::MAP_AW-1:0]   addr;
   logic                          in_range;
   logic                          load;

   logic       s1_valid_ff;
   logic       s1_valid_in;
   logic [1:0] op_ff;
   logic [7:0] byte_ff;
   logic       hit_ff;
   logic [7:0] rd_ff;

   assign addr     = req.byte_value[rpcp_pkg::MAP_AW-1:0];
   assign in_range = ({1'b0, req.byte_value} < 9'(rpcp_pkg::ALPHABET));
   assign load     = take && (req.operation == rpcp_pkg::OP_LOAD) && in_range;

   always_comb begin
      map_valid_in = map_valid_ff;
      if (load) begin
         map_valid_in[addr] = 1'b1;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         map_valid_ff <= map_valid_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rank_mem[addr] <= req.rank;
      end
      if (take) begin
         rd_ff <= rank_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff   <= req.operation;
         byte_ff <= req.byte_value;
         hit_ff  <= in_range && map_valid_ff[addr];
      end
   end

   assign lookup.valid       = s1_valid_ff;
   assign lookup.operation   = op_ff;
   assign lookup.byte_value  = byte_ff;
   assign lookup.hit         = hit_ff;
   assign lookup.mapped_rank = rd_ff;

endmodule

`default_nettype wire

FILE: src/rpcp_encode.sv
`timescale 1ns / 1ps
`default_nettype none

module rpcp_encode (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire rpcp_pkg::rpcp_lookup_type        lookup,
   input  wire logic [rpcp_pkg::LEN_W-1:0]       esc_len,
   input  wire logic                             room,
   output logic                                  advance,
   output rpcp_pkg::rpcp_push_type               push
);

   logic [7:0]                   partial_ff;
   logic [7:0]                   partial_in;
   logic [2:0]                   fill_ff;
   logic [2:0]                   fill_in;
   logic [7:0]                   rk;
   logic [rpcp_pkg::CODE_W-1:0]  code;
   logic [rpcp_pkg::LEN_W-1:0]   len;
   logic [rpcp_pkg::CODE_W:0]    mask;
   logic [23:0]                  acc;
   logic [4:0]                   total;
   logic [1:0]                   n;

   assign rk = lookup.hit ? lookup.mapped_rank : lookup.byte_value;

   always_comb begin
      mask = (13'd1 << esc_len) - 13'd1;
      if (rk < 8'(rpcp_pkg::FIXED_RANKS)) begin
         code = 12'(rpcp_pkg::fixed_value(rk[2:0]));
         len  = rpcp_pkg::fixed_length(rk[2:0]);
      end else begin
         code = {1'b0, rk, rpcp_pkg::ESC_PREFIX} & mask[rpcp_pkg::CODE_W-1:0];
         len  = esc_len;
      end
      acc   = {16'd0, partial_ff} | ({12'd0, code} << fill_ff);
      total = {2'b00, fill_ff} + {1'b0, len};
      if (total[4]) begin
         n = 2'd2;
      end else if (total[3]) begin
         n = 2'd1;
      end else begin
         n = 2'd0;
      end
   end

   assign advance = lookup.valid && room;

   always_comb begin
      push.count             = 2'd0;
      push.data0.packed_byte = acc[7:0];
      push.data0.last        = 1'b1;
      push.data1.packed_byte = acc[15:8];
      push.data1.last        = 1'b1;
      partial_in             = partial_ff;
      fill_in                = fill_ff;
      if (advance) begin
         unique case (lookup.operation)
            rpcp_pkg::OP_ENCODE: begin
               push.count      = n;
               push.data0.last = (n == 2'd1);
               fill_in         = total[2:0];
               unique case (n)
                  2'd2:    partial_in = acc[23:16];
                  2'd1:    partial_in = acc[15:8];
                  default: partial_in = acc[7:0];
               endcase
            end
            rpcp_pkg::OP_FLUSH: begin
               if (fill_ff != 3'd0) begin
                  push.count             = 2'd1;
                  push.data0.packed_byte = partial_ff;
                  partial_in             = 8'd0;
                  fill_in                = 3'd0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 8'd0;
         fill_ff    <= 3'd0;
      end else begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/rpcp_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module rpcp_out_fifo (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rpcp_pkg::rpcp_push_type push,
   output logic                         room,
   output logic                         rsp_valid,
   output rpcp_pkg::rpcp_rsp_type       rsp_data,
   input  wire logic                    rsp_stall
);

   rpcp_pkg::rpcp_rsp_type          entry_ff [rpcp_pkg::FIFO_DEPTH];
   logic [rpcp_pkg::FIFO_AW-1:0]    wr_ptr_ff;
   logic [rpcp_pkg::FIFO_AW-1:0]    wr_ptr_in;
   logic [rpcp_pkg::FIFO_AW-1:0]    rd_ptr_ff;
   logic [rpcp_pkg::FIFO_AW-1:0]    rd_ptr_in;
   logic [rpcp_pkg::FIFO_CW-1:0]    count_ff;
   logic [rpcp_pkg::FIFO_CW-1:0]    count_in;
   logic [rpcp_pkg::FIFO_CW-1:0]    left;
   logic [rpcp_pkg::FIFO_AW-1:0]    wr_next;
   logic                            pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign left      = count_ff - rpcp_pkg::FIFO_CW'(pop);
   // need space for a two-byte transfer
   assign room      = (left <= rpcp_pkg::FIFO_CW'(rpcp_pkg::FIFO_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + rpcp_pkg::FIFO_AW'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + rpcp_pkg::FIFO_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + rpcp_pkg::FIFO_AW'(pop);
      count_in  = left + rpcp_pkg::FIFO_CW'(push.count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.data0;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.data1;
      end
   end

endmodule

`default_nettype wire

FILE: src/rank_prefix_code_packer.sv
// channel   dir  handshake            payload
// req_      in   req_valid/req_stall  rpcp_req_type (operation, byte_value, rank)
// rsp_      out  rsp_valid/rsp_stall  rpcp_rsp_type (packed_byte, last)
// csr_      in   csr_wr_en            dict_size, 9 bits
//
// One item per cycle while req_stall is low. Each accepted item passes the
// synchronous rank map read, then code assembly, into the output queue.
// req_stall rises only while the 4-entry output queue has no space for a
// two-byte transfer. Synchronous reset clears the map valid bits, bit buffer
// and queue and sets dict_size to 256; no clearing pass, so no startup wait.
`timescale 1ns / 1ps
`default_nettype none

module rank_prefix_code_packer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire rpcp_pkg::rpcp_req_type        req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rpcp_pkg::rpcp_rsp_type             rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [rpcp_pkg::DICT_W-1:0]   csr_wr_data
);

   rpcp_pkg::rpcp_lookup_type      lookup;
   rpcp_pkg::rpcp_push_type        push;
   logic [rpcp_pkg::LEN_W-1:0]     esc_len_ff;
   logic [rpcp_pkg::LEN_W-1:0]     esc_len_in;
   logic                           take;
   logic                           advance;
   logic                           room;

   assign req_stall = lookup.valid && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      esc_len_in = esc_len_ff;
      if (csr_wr_en) begin
         esc_len_in = rpcp_pkg::esc_length(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_len_ff <= rpcp_pkg::esc_length(rpcp_pkg::DICT_RESET);
      end else begin
         esc_len_ff <= esc_len_in;
      end
   end

   rpcp_map u_map (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .req     (req_data),
      .advance (advance),
      .lookup  (lookup)
   );

   rpcp_encode u_encode (
      .clock   (clock),
      .reset   (reset),
      .lookup  (lookup),
      .esc_len (esc_len_ff),
      .room    (room),
      .advance (advance),
      .push    (push)
   );

   rpcp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

FILE: src/rpcp_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rpcp_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_stall,
   input wire rpcp_pkg::rpcp_req_type        req_data,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_stall,
   input wire rpcp_pkg::rpcp_rsp_type        rsp_data
);

   // a stalled request transfer holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_data))
      else $error("req payload changed under stall");

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   // with the output queue drained there is always room downstream
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled while output queue empty");

   // req stalls only while results wait in the queue
   a_stall_needs_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req stalled with nothing to deliver");

endmodule

bind rank_prefix_code_packer rpcp_checker u_rpcp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
